// ===== hw/rtl/rcx_pkg.sv =====
// shared constants and opcode codes for the redcode execute unit
package rcx_pkg;

  // fixed field widths and defaults
  localparam int unsigned TAG_W           = 13;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 16;
  localparam logic [CFG_W-1:0] CORE_SIZE_RST = 16'd8000;

  // action codes
  localparam logic [3:0] ACT_MOV = 4'd0;
  localparam logic [3:0] ACT_ADD = 4'd1;
  localparam logic [3:0] ACT_SUB = 4'd2;
  localparam logic [3:0] ACT_MUL = 4'd3;
  localparam logic [3:0] ACT_DIV = 4'd4;
  localparam logic [3:0] ACT_MOD = 4'd5;
  localparam logic [3:0] ACT_JMZ = 4'd6;
  localparam logic [3:0] ACT_JMN = 4'd7;
  localparam logic [3:0] ACT_DJN = 4'd8;
  localparam logic [3:0] ACT_SEQ = 4'd9;
  localparam logic [3:0] ACT_SNE = 4'd10;
  localparam logic [3:0] ACT_SLT = 4'd11;

  // modifier codes
  localparam logic [2:0] MDF_A   = 3'd0;
  localparam logic [2:0] MDF_AB  = 3'd1;
  localparam logic [2:0] MDF_BA  = 3'd2;
  localparam logic [2:0] MDF_B   = 3'd3;
  localparam logic [2:0] MDF_F   = 3'd4;
  localparam logic [2:0] MDF_X   = 3'd5;
  localparam logic [2:0] MDF_I   = 3'd6;
  localparam logic [2:0] MDF_BAD = 3'd7;

endpackage

// ===== hw/rtl/redcode_instruction_execute_unit.sv =====
// top level of the redcode instruction execute unit
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | start / busy         | in_action .. in_jump_offset
//  result   | out_strobe (1 cycle) | out_new_dst_a .. out_bad_modifier
//  config   | cfg_we               | cfg_wdata (core size)
//
//  one request enters per cycle while busy is low; each passes input register,
//  the operand reduction divider (VALUE_WIDTH stages), the decode register, the
//  lane divider behind the multiplier (2*VALUE_WIDTH stages) and output register
//  busy is high during reset and in the first cycle after it; no clearing pass
//  the receiver cannot stall, so the pipeline never holds
module redcode_instruction_execute_unit #(
  parameter int unsigned VALUE_WIDTH = rcx_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    in_action,
  input  logic [2:0]                    in_modifier,
  input  logic [VALUE_WIDTH-1:0]        in_src_a,
  input  logic [VALUE_WIDTH-1:0]        in_src_b,
  input  logic [VALUE_WIDTH-1:0]        in_dst_a,
  input  logic [VALUE_WIDTH-1:0]        in_dst_b,
  input  logic [rcx_pkg::TAG_W-1:0]     in_src_tag,
  input  logic [rcx_pkg::TAG_W-1:0]     in_dst_tag,
  input  logic [VALUE_WIDTH-1:0]        in_jump_offset,
  output logic                          out_strobe,
  output logic [VALUE_WIDTH-1:0]        out_new_dst_a,
  output logic [VALUE_WIDTH-1:0]        out_new_dst_b,
  output logic [rcx_pkg::TAG_W-1:0]     out_new_dst_tag,
  output logic [VALUE_WIDTH-1:0]        out_next_offset,
  output logic                          out_skip,
  output logic                          out_divide_fault,
  output logic                          out_bad_modifier,
  input  logic                          cfg_we,
  input  logic [rcx_pkg::CFG_W-1:0]     cfg_wdata
);
  import rcx_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned MW = ((W > CFG_W) ? W : CFG_W) + 1;
  localparam int unsigned PW = 2 * W;

  typedef struct packed {
    logic [3:0]       act;
    logic [2:0]       mdf;
    logic [W-1:0]     sa;
    logic [W-1:0]     sb;
    logic [W-1:0]     da;
    logic [W-1:0]     db;
    logic [W-1:0]     off;
    logic [TAG_W-1:0] stag;
    logic [TAG_W-1:0] dtag;
  } item_t;

  typedef struct packed {
    logic [W-1:0]     na;
    logic [W-1:0]     nb;
    logic [TAG_W-1:0] ntag;
    logic [W-1:0]     next;
    logic             skip;
    logic             fault;
    logic             bad;
    logic             wa;
    logic             wb;
    logic             use_quo;
  } res_t;

  // core size register and modulus
  logic [CFG_W-1:0] core_r;
  logic [MW-1:0]    mod_w;
  logic             busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_r <= CORE_SIZE_RST;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        core_r <= cfg_wdata;
      end
    end
  end

  assign busy  = busy_r;
  assign mod_w = (core_r == '0) ? (MW'(1) << W) : MW'(core_r);

  // input register
  logic  s0_v_r;
  item_t s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_r.act  <= in_action;
    s0_r.mdf  <= in_modifier;
    s0_r.sa   <= in_src_a;
    s0_r.sb   <= in_src_b;
    s0_r.da   <= in_dst_a;
    s0_r.db   <= in_dst_b;
    s0_r.off  <= in_jump_offset;
    s0_r.stag <= in_src_tag;
    s0_r.dtag <= in_dst_tag;
  end

  // operand reduction modulo core size
  logic [W-1:0]  red_q_sa, red_q_sb, red_q_da, red_q_db;
  logic [MW-1:0] red_sa, red_sb, red_da, red_db;

  rcx_div #(.NUM_W(W), .DEN_W(MW)) u_red_sa (
    .clk(clk), .num_i(s0_r.sa), .den_i(mod_w), .quo_o(red_q_sa), .rem_o(red_sa));
  rcx_div #(.NUM_W(W), .DEN_W(MW)) u_red_sb (
    .clk(clk), .num_i(s0_r.sb), .den_i(mod_w), .quo_o(red_q_sb), .rem_o(red_sb));
  rcx_div #(.NUM_W(W), .DEN_W(MW)) u_red_da (
    .clk(clk), .num_i(s0_r.da), .den_i(mod_w), .quo_o(red_q_da), .rem_o(red_da));
  rcx_div #(.NUM_W(W), .DEN_W(MW)) u_red_db (
    .clk(clk), .num_i(s0_r.db), .den_i(mod_w), .quo_o(red_q_db), .rem_o(red_db));

  // item delay alongside the reduction
  item_t dl1_r   [W];
  logic  dl1_v_r [W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < W; k++) begin
        dl1_v_r[k] <= 1'b0;
      end
    end else begin
      dl1_v_r[0] <= s0_v_r;
      for (int k = 1; k < W; k++) begin
        dl1_v_r[k] <= dl1_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl1_r[0] <= s0_r;
    for (int k = 1; k < W; k++) begin
      dl1_r[k] <= dl1_r[k-1];
    end
  end

  // decode, short arithmetic, jumps and compares
  item_t        it;
  res_t         pres_nxt;
  logic [PW-1:0] numa_nxt, numb_nxt;
  logic [MW-1:0] dena_nxt, denb_nxt;

  assign it = dl1_r[W-1];

  always_comb begin
    logic [W-1:0]  ra, rb, xa, xb, fa, fb;
    logic          usea, useb, cond;
    logic [MW-1:0] suma, sumb, difa, difb, deca, decb;
    ra   = red_sa[W-1:0];
    rb   = red_sb[W-1:0];
    xa   = red_da[W-1:0];
    xb   = red_db[W-1:0];
    usea = (it.mdf == MDF_A) || (it.mdf == MDF_BA) || (it.mdf == MDF_F) ||
           (it.mdf == MDF_X) || (it.mdf == MDF_I);
    useb = (it.mdf == MDF_AB) || (it.mdf == MDF_B) || (it.mdf == MDF_F) ||
           (it.mdf == MDF_X) || (it.mdf == MDF_I);
    fa   = ((it.mdf == MDF_BA) || (it.mdf == MDF_X)) ? rb : ra;
    fb   = ((it.mdf == MDF_AB) || (it.mdf == MDF_X)) ? ra : rb;

    suma = MW'(xa) + MW'(fa);
    sumb = MW'(xb) + MW'(fb);
    if (suma >= mod_w) suma = suma - mod_w;
    if (sumb >= mod_w) sumb = sumb - mod_w;
    difa = (mod_w - MW'(fa)) + MW'(xa);
    difb = (mod_w - MW'(fb)) + MW'(xb);
    if (difa >= mod_w) difa = difa - mod_w;
    if (difb >= mod_w) difb = difb - mod_w;
    deca = (xa == '0) ? (mod_w - MW'(1)) : (MW'(xa) - MW'(1));
    decb = (xb == '0) ? (mod_w - MW'(1)) : (MW'(xb) - MW'(1));

    // lane divider operands: product mod core size, or d / s
    if (it.act == ACT_MUL) begin
      numa_nxt = PW'(xa) * PW'(fa);
      numb_nxt = PW'(xb) * PW'(fb);
      dena_nxt = mod_w;
      denb_nxt = mod_w;
    end else begin
      numa_nxt = PW'(xa);
      numb_nxt = PW'(xb);
      dena_nxt = MW'(fa);
      denb_nxt = MW'(fb);
    end

    pres_nxt         = '0;
    pres_nxt.na      = it.da;
    pres_nxt.nb      = it.db;
    pres_nxt.ntag    = it.dtag;
    pres_nxt.next    = W'(1);
    pres_nxt.use_quo = (it.act == ACT_DIV);
    cond             = 1'b0;

    if (it.mdf == MDF_BAD) begin
      pres_nxt.bad = 1'b1;
    end else begin
      case (it.act)
        ACT_MOV: begin
          if (it.mdf == MDF_I) begin
            pres_nxt.na   = ra;
            pres_nxt.nb   = rb;
            pres_nxt.ntag = it.stag;
          end else begin
            if (usea) pres_nxt.na = fa;
            if (useb) pres_nxt.nb = fb;
          end
        end
        ACT_ADD: begin
          if (usea) pres_nxt.na = W'(suma);
          if (useb) pres_nxt.nb = W'(sumb);
        end
        ACT_SUB: begin
          if (usea) pres_nxt.na = W'(difa);
          if (useb) pres_nxt.nb = W'(difb);
        end
        ACT_MUL: begin
          pres_nxt.wa = usea;
          pres_nxt.wb = useb;
        end
        ACT_DIV, ACT_MOD: begin
          if ((usea && fa == '0) || (useb && fb == '0)) begin
            pres_nxt.fault = 1'b1;
          end else begin
            pres_nxt.wa = usea;
            pres_nxt.wb = useb;
          end
        end
        ACT_JMZ: begin
          cond = (!usea || xa == '0) && (!useb || xb == '0);
          if (cond) pres_nxt.next = it.off;
        end
        ACT_JMN: begin
          cond = (usea && xa != '0) || (useb && xb != '0);
          if (cond) pres_nxt.next = it.off;
        end
        ACT_DJN: begin
          if (usea) pres_nxt.na = W'(deca);
          if (useb) pres_nxt.nb = W'(decb);
          cond = (usea && deca != '0) || (useb && decb != '0);
          if (cond) pres_nxt.next = it.off;
        end
        ACT_SEQ, ACT_SNE: begin
          cond = (!usea || fa == xa) && (!useb || fb == xb);
          if (it.mdf == MDF_I && it.stag != it.dtag) cond = 1'b0;
          pres_nxt.skip = (it.act == ACT_SEQ) ? cond : !cond;
        end
        ACT_SLT: begin
          pres_nxt.skip = (!usea || fa < xa) && (!useb || fb < xb);
        end
        default: begin
          cond = 1'b0;
        end
      endcase
    end
  end

  // decode stage registers
  logic          pv_r;
  res_t          pres_r;
  logic [PW-1:0] numa_r, numb_r;
  logic [MW-1:0] dena_r, denb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= dl1_v_r[W-1];
    end
  end

  always_ff @(posedge clk) begin
    pres_r <= pres_nxt;
    numa_r <= numa_nxt;
    numb_r <= numb_nxt;
    dena_r <= dena_nxt;
    denb_r <= denb_nxt;
  end

  // lane dividers for mul, div and mod
  logic [PW-1:0] quo_a, quo_b;
  logic [MW-1:0] rem_a, rem_b;

  rcx_div #(.NUM_W(PW), .DEN_W(MW)) u_lane_a (
    .clk(clk), .num_i(numa_r), .den_i(dena_r), .quo_o(quo_a), .rem_o(rem_a));
  rcx_div #(.NUM_W(PW), .DEN_W(MW)) u_lane_b (
    .clk(clk), .num_i(numb_r), .den_i(denb_r), .quo_o(quo_b), .rem_o(rem_b));

  // result delay alongside the lane dividers
  res_t dl2_r   [PW];
  logic dl2_v_r [PW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PW; k++) begin
        dl2_v_r[k] <= 1'b0;
      end
    end else begin
      dl2_v_r[0] <= pv_r;
      for (int k = 1; k < PW; k++) begin
        dl2_v_r[k] <= dl2_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl2_r[0] <= pres_r;
    for (int k = 1; k < PW; k++) begin
      dl2_r[k] <= dl2_r[k-1];
    end
  end

  // output register
  res_t         fin;
  logic         strobe_r;
  logic [W-1:0] na_r, nb_r, next_r;
  logic [TAG_W-1:0] ntag_r;
  logic         skip_r, fault_r, bad_r;

  assign fin = dl2_r[PW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dl2_v_r[PW-1];
    end
  end

  always_ff @(posedge clk) begin
    na_r    <= fin.wa ? (fin.use_quo ? quo_a[W-1:0] : rem_a[W-1:0]) : fin.na;
    nb_r    <= fin.wb ? (fin.use_quo ? quo_b[W-1:0] : rem_b[W-1:0]) : fin.nb;
    ntag_r  <= fin.ntag;
    next_r  <= fin.next;
    skip_r  <= fin.skip;
    fault_r <= fin.fault;
    bad_r   <= fin.bad;
  end

  assign out_strobe       = strobe_r;
  assign out_new_dst_a    = na_r;
  assign out_new_dst_b    = nb_r;
  assign out_new_dst_tag  = ntag_r;
  assign out_next_offset  = next_r;
  assign out_skip         = skip_r;
  assign out_divide_fault = fault_r;
  assign out_bad_modifier = bad_r;

endmodule

// ===== hw/rtl/rcx_div.sv =====
// pipelined restoring divider, one quotient bit per register stage
module rcx_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  logic [DEN_W-1:0] rem_r   [NUM_W];
  logic [DEN_W-1:0] rem_nxt [NUM_W];
  logic [DEN_W-1:0] den_r   [NUM_W];
  logic [DEN_W-1:0] den_nxt [NUM_W];
  logic [NUM_W-1:0] num_r   [NUM_W];
  logic [NUM_W-1:0] num_nxt [NUM_W];
  logic [NUM_W-1:0] quo_r   [NUM_W];
  logic [NUM_W-1:0] quo_nxt [NUM_W];

  // one trial subtract per stage
  always_comb begin
    logic [DEN_W-1:0] rin;
    logic [DEN_W-1:0] din;
    logic [NUM_W-1:0] nin;
    logic [NUM_W-1:0] qin;
    logic [DEN_W:0]   trial;
    logic             ge;
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        rin = '0;
        din = den_i;
        nin = num_i;
        qin = '0;
      end else begin
        rin = rem_r[k-1];
        din = den_r[k-1];
        nin = num_r[k-1];
        qin = quo_r[k-1];
      end
      trial      = {rin, nin[NUM_W-1]};
      ge         = (trial >= {1'b0, din});
      rem_nxt[k] = ge ? DEN_W'(trial - {1'b0, din}) : trial[DEN_W-1:0];
      den_nxt[k] = din;
      num_nxt[k] = nin << 1;
      quo_nxt[k] = {qin[NUM_W-2:0], ge};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_W; k++) begin
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= den_nxt[k];
      num_r[k] <= num_nxt[k];
      quo_r[k] <= quo_nxt[k];
    end
  end

  assign quo_o = quo_r[NUM_W-1];
  assign rem_o = rem_r[NUM_W-1];

endmodule

// ===== hw/rtl/rcx_chk.sv =====
// port-level checker for the redcode execute unit, with its bind
module rcx_chk #(
  parameter int unsigned VALUE_WIDTH = rcx_pkg::VALUE_WIDTH_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [3:0]                in_action,
  input logic [2:0]                in_modifier,
  input logic [VALUE_WIDTH-1:0]    in_src_a,
  input logic [VALUE_WIDTH-1:0]    in_src_b,
  input logic [VALUE_WIDTH-1:0]    in_dst_a,
  input logic [VALUE_WIDTH-1:0]    in_dst_b,
  input logic [rcx_pkg::TAG_W-1:0] in_src_tag,
  input logic [rcx_pkg::TAG_W-1:0] in_dst_tag,
  input logic [VALUE_WIDTH-1:0]    in_jump_offset,
  input logic                      out_strobe,
  input logic [VALUE_WIDTH-1:0]    out_new_dst_a,
  input logic [VALUE_WIDTH-1:0]    out_new_dst_b,
  input logic [rcx_pkg::TAG_W-1:0] out_new_dst_tag,
  input logic [VALUE_WIDTH-1:0]    out_next_offset,
  input logic                      out_skip,
  input logic                      out_divide_fault,
  input logic                      out_bad_modifier,
  input logic                      cfg_we,
  input logic [rcx_pkg::CFG_W-1:0] cfg_wdata
);
  import rcx_pkg::*;

  localparam int unsigned LAT   = 3 * VALUE_WIDTH + 3;
  localparam int unsigned AGE_W = $clog2(LAT + 1);

  // cycles since reset release, saturating
  logic [AGE_W-1:0] age_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= '0;
    end else if (age_r != AGE_W'(LAT)) begin
      age_r <= age_r + AGE_W'(1);
    end
  end

  // every request gives exactly one result at fixed latency
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (age_r == AGE_W'(LAT)) |-> (out_strobe == $past(start && !busy, LAT)))
    else $error("result strobe does not match request latency");

  // bad modifier gives a plain pass-through result
  a_bad_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bad_modifier) |->
      (!out_skip && !out_divide_fault && out_next_offset == VALUE_WIDTH'(1)))
    else $error("bad modifier result carries other flags");

  // skip, fault and bad modifier are exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($countones({out_skip, out_divide_fault, out_bad_modifier}) <= 1))
    else $error("more than one result flag set");

  // a fault or a skip never comes with a taken jump
  a_no_jump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_skip || out_divide_fault)) |-> (out_next_offset == VALUE_WIDTH'(1)))
    else $error("jump offset with compare or divide result");

  // busy only in the cycle after reset
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset recovery");

endmodule

bind redcode_instruction_execute_unit rcx_chk #(.VALUE_WIDTH(VALUE_WIDTH)) u_rcx_chk (.*);

// ===== tb/redcode_execute_checker.sv =====
// result predictor and scoreboard for the redcode execute unit
module redcode_execute_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [3:0]                in_action,
  input  logic [2:0]                in_modifier,
  input  logic [15:0]               in_src_a,
  input  logic [15:0]               in_src_b,
  input  logic [15:0]               in_dst_a,
  input  logic [15:0]               in_dst_b,
  input  logic [rcx_pkg::TAG_W-1:0] in_src_tag,
  input  logic [rcx_pkg::TAG_W-1:0] in_dst_tag,
  input  logic [15:0]               in_jump_offset,
  input  logic                      out_strobe,
  input  logic [15:0]               out_new_dst_a,
  input  logic [15:0]               out_new_dst_b,
  input  logic [rcx_pkg::TAG_W-1:0] out_new_dst_tag,
  input  logic [15:0]               out_next_offset,
  input  logic                      out_skip,
  input  logic                      out_divide_fault,
  input  logic                      out_bad_modifier,
  input  logic                      cfg_we,
  input  logic [rcx_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcx_pkg::*;

  typedef struct {
    logic [15:0]      dst_a;
    logic [15:0]      dst_b;
    logic [TAG_W-1:0] dst_tag;
    logic [15:0]      next_offset;
    logic             skip;
    logic             divide_fault;
    logic             bad_modifier;
  } exec_result_t;

  exec_result_t      expected_q[$];
  logic [CFG_W-1:0]  core_size;

  // one field of add, sub, mul, div or mod
  function automatic longint unsigned field_arith(input logic [3:0] act,
      input longint unsigned d, input longint unsigned s, input longint unsigned m);
    case (act)
      ACT_ADD: return (d + s) % m;
      ACT_SUB: return (d + m - s) % m;
      ACT_MUL: return (d * s) % m;
      ACT_DIV: return (d / s) % m;
      default: return (d % s) % m;
    endcase
  endfunction

  // expected result of one request under the current core size
  function automatic exec_result_t execute_instr(input logic [3:0] act,
      input logic [2:0] mdf, input logic [15:0] sa, input logic [15:0] sb,
      input logic [15:0] da, input logic [15:0] db, input logic [TAG_W-1:0] stag,
      input logic [TAG_W-1:0] dtag, input logic [15:0] off);
    exec_result_t r;
    longint unsigned m, ra, rb, xa, xb, for_a, for_b;
    r.dst_a = da; r.dst_b = db; r.dst_tag = dtag; r.next_offset = 16'd1;
    r.skip = 1'b0; r.divide_fault = 1'b0; r.bad_modifier = 1'b0;
    m = (core_size == 0) ? 64'd65536 : 64'(core_size);
    if (mdf == MDF_BAD) begin
      r.bad_modifier = 1'b1;
    end else if (act <= ACT_SLT) begin
      logic use_a, use_b, hit;
      use_a = (mdf == MDF_A || mdf == MDF_BA || mdf >= MDF_F);
      use_b = (mdf == MDF_AB || mdf == MDF_B || mdf >= MDF_F);
      ra = sa % m; rb = sb % m; xa = da % m; xb = db % m;
      for_a = (mdf == MDF_BA || mdf == MDF_X) ? rb : ra;
      for_b = (mdf == MDF_AB || mdf == MDF_X) ? ra : rb;
      case (act)
        ACT_MOV: begin
          if (mdf == MDF_I) begin
            r.dst_a = ra[15:0]; r.dst_b = rb[15:0]; r.dst_tag = stag;
          end else begin
            if (use_a) r.dst_a = for_a[15:0];
            if (use_b) r.dst_b = for_b[15:0];
          end
        end
        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
          if ((act == ACT_DIV || act == ACT_MOD) &&
              ((use_a && for_a == 0) || (use_b && for_b == 0))) begin
            r.divide_fault = 1'b1;
          end else begin
            if (use_a) r.dst_a = 16'(field_arith(act, xa, for_a, m));
            if (use_b) r.dst_b = 16'(field_arith(act, xb, for_b, m));
          end
        end
        ACT_JMZ: begin
          hit = (!use_a || xa == 0) && (!use_b || xb == 0);
          if (hit) r.next_offset = off;
        end
        ACT_JMN: begin
          hit = (use_a && xa != 0) || (use_b && xb != 0);
          if (hit) r.next_offset = off;
        end
        ACT_DJN: begin
          // decrement first, then test
          if (use_a) begin xa = (xa + m - 1) % m; r.dst_a = xa[15:0]; end
          if (use_b) begin xb = (xb + m - 1) % m; r.dst_b = xb[15:0]; end
          hit = (use_a && xa != 0) || (use_b && xb != 0);
          if (hit) r.next_offset = off;
        end
        ACT_SEQ, ACT_SNE: begin
          hit = (!use_a || for_a == xa) && (!use_b || for_b == xb);
          if (mdf == MDF_I && stag != dtag) hit = 1'b0;
          r.skip = (act == ACT_SEQ) ? hit : !hit;
        end
        default: begin
          r.skip = (!use_a || for_a < xa) && (!use_b || for_b < xb);
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
      input longint unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    core_size = CORE_SIZE_RST;
  end

  // watch config, requests and results
  always @(posedge clk) begin
    exec_result_t e;
    if (!rst_n) begin
      core_size <= CORE_SIZE_RST;
    end else begin
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_new_dst_a, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_new_dst_a !== e.dst_a) report_mismatch("dst_a", out_new_dst_a, e.dst_a);
          if (out_new_dst_b !== e.dst_b) report_mismatch("dst_b", out_new_dst_b, e.dst_b);
          if (out_new_dst_tag !== e.dst_tag)
            report_mismatch("dst_tag", out_new_dst_tag, e.dst_tag);
          if (out_next_offset !== e.next_offset)
            report_mismatch("next_offset", out_next_offset, e.next_offset);
          if (out_skip !== e.skip) report_mismatch("skip", out_skip, e.skip);
          if (out_divide_fault !== e.divide_fault)
            report_mismatch("divide_fault", out_divide_fault, e.divide_fault);
          if (out_bad_modifier !== e.bad_modifier)
            report_mismatch("bad_modifier", out_bad_modifier, e.bad_modifier);
        end
      end
      if (start && !busy)
        expected_q.push_back(execute_instr(in_action, in_modifier, in_src_a, in_src_b,
            in_dst_a, in_dst_b, in_src_tag, in_dst_tag, in_jump_offset));
      if (cfg_we) core_size <= cfg_wdata;
    end
    pending_count <= expected_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// stimulus and verdict for the redcode execute unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcx_pkg::*;

  localparam int DRAIN_CYCLES = 60;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [3:0]        in_action;
  logic [2:0]        in_modifier;
  logic [15:0]       in_src_a, in_src_b, in_dst_a, in_dst_b, in_jump_offset;
  logic [TAG_W-1:0]  in_src_tag, in_dst_tag;
  logic              out_strobe;
  logic [15:0]       out_new_dst_a, out_new_dst_b, out_next_offset;
  logic [TAG_W-1:0]  out_new_dst_tag;
  logic              out_skip, out_divide_fault, out_bad_modifier;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  int                fail_count, pending_count;
  logic [CFG_W-1:0]  cur_core;
  bit                no_gaps;

  redcode_instruction_execute_unit u_dut (.*);
  redcode_execute_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end

  // random field value, mostly below core size, sometimes anywhere or zero
  function automatic logic [15:0] pick_value();
    int unsigned m, sel;
    m = (cur_core == 0) ? 65536 : cur_core;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'd0;
    if (sel == 1) return 16'($urandom_range(0, 65535));
    if (sel == 2) return 16'(m - 1);
    return 16'($urandom_range(0, m - 1));
  endfunction

  // present one request, wait for acceptance, then an optional gap
  task automatic send_req(input logic [3:0] act, input logic [2:0] mdf,
      input logic [15:0] sa, input logic [15:0] sb, input logic [15:0] da,
      input logic [15:0] db, input logic [TAG_W-1:0] stag,
      input logic [TAG_W-1:0] dtag, input logic [15:0] off);
    int gap;
    start <= 1'b1;
    in_action <= act; in_modifier <= mdf;
    in_src_a <= sa; in_src_b <= sb; in_dst_a <= da; in_dst_b <= db;
    in_src_tag <= stag; in_dst_tag <= dtag; in_jump_offset <= off;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic rand_req();
    logic [TAG_W-1:0] stag;
    stag = 13'($urandom);
    send_req(4'($urandom_range(0, 15) < 14 ? $urandom_range(0, 11) : $urandom_range(12, 15)),
        3'($urandom_range(0, 15) == 0 ? MDF_BAD : $urandom_range(0, 6)),
        pick_value(), pick_value(), pick_value(), pick_value(), stag,
        ($urandom_range(0, 2) == 0) ? stag : 13'($urandom), 16'($urandom));
  endtask

  // wait until every expected result has come, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_core(input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cur_core = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] sizes[7];
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_action = ACT_MOV; in_modifier = MDF_A;
    in_src_a = '0; in_src_b = '0; in_dst_a = '0; in_dst_b = '0;
    in_src_tag = '0; in_dst_tag = '0; in_jump_offset = '0;
    cur_core = CORE_SIZE_RST;
    no_gaps = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every action once, then the corner cases
    for (int a = 0; a <= ACT_SLT; a++)
      send_req(4'(a), 3'(a % 7), 16'd5, 16'd3, 16'd7, 16'd0, 13'h0abc, 13'h1234, 16'd99);
    send_req(ACT_MOV, MDF_I, 16'd7999, 16'd1, 16'd2, 16'd3, 13'h1fff, 13'h0000, 16'd0);
    send_req(ACT_ADD, MDF_F, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 13'h1fff, 13'h1fff,
        16'hffff);
    send_req(ACT_SUB, MDF_X, 16'd1, 16'd7999, 16'd0, 16'd0, 13'h0, 13'h0, 16'd0);
    send_req(ACT_DIV, MDF_F, 16'd0, 16'd3, 16'd9, 16'd9, 13'h0, 13'h0, 16'd0);
    send_req(ACT_MOD, MDF_AB, 16'd8000, 16'd3, 16'd9, 16'd9, 13'h0, 13'h0, 16'd0);
    send_req(ACT_MUL, MDF_B, 16'd7999, 16'd7999, 16'd7999, 16'd7999, 13'h0, 13'h0, 16'd0);
    send_req(ACT_JMZ, MDF_I, 16'd1, 16'd1, 16'd0, 16'd8000, 13'h0, 13'h0, 16'd1234);
    send_req(ACT_DJN, MDF_A, 16'd0, 16'd0, 16'd1, 16'd0, 13'h0, 13'h0, 16'd55);
    send_req(ACT_DJN, MDF_F, 16'd0, 16'd0, 16'd0, 16'd2, 13'h0, 13'h0, 16'd55);
    send_req(ACT_SEQ, MDF_I, 16'd4, 16'd4, 16'd4, 16'd4, 13'h0001, 13'h0002, 16'd0);
    send_req(ACT_SNE, MDF_I, 16'd4, 16'd4, 16'd4, 16'd4, 13'h0155, 13'h0155, 16'd0);
    send_req(ACT_SLT, MDF_I, 16'd1, 16'd2, 16'd3, 16'd2, 13'h0, 13'h1, 16'd0);
    send_req(ACT_ADD, MDF_BAD, 16'd1, 16'd2, 16'd3, 16'd4, 13'h1, 13'h2, 16'd9);
    send_req(4'd13, MDF_F, 16'd1, 16'd2, 16'd3, 16'd4, 13'h1, 13'h2, 16'd9);
    send_req(4'd15, MDF_I, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 13'h1fff, 13'h0, 16'd9);
    drain();

    // random phases over several core sizes, extremes included
    sizes = '{16'd8000, 16'd2, 16'hffff, 16'd0, 16'd1, 16'd7, 16'($urandom_range(3, 65534))};
    foreach (sizes[p]) begin
      write_core(sizes[p]);
      for (int i = 0; i < 70; i++) begin
        no_gaps = (i >= 20 && i < 40);
        rand_req();
      end
      no_gaps = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== redcode_instruction_execute_unit.f =====
hw/rtl/rcx_pkg.sv
hw/rtl/rcx_div.sv
hw/rtl/redcode_instruction_execute_unit.sv
hw/rtl/rcx_chk.sv
tb/redcode_execute_checker.sv
tb/tb.sv
